### src/swetd_pkg.sv
// ----------------------------------------------------------------------------
// swetd_pkg: shared types and constants of the sync word detector
// Field widths, register indexes, reset values and the 24-bit popcount.
// ----------------------------------------------------------------------------
package swetd_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned SYNC_W     = 24;
	localparam int unsigned ERR_W      = 5;
	localparam int unsigned FRAME_W    = 7;
	localparam int unsigned HIST_W     = 32;
	localparam int unsigned FILL_W     = 3;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 24;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT  = 4'd1;

	// Register reset values.
	localparam logic [SYNC_W-1:0] SYNC_RESET  = 24'hF9A8ED;
	localparam logic [ERR_W-1:0]  LIMIT_RESET = 5'd2;

	// Fill levels at which each check becomes valid.
	localparam logic [FILL_W-1:0] FILL_ALIGNED = 3'd3;
	localparam logic [FILL_W-1:0] FILL_FULL    = 3'd4;

	// Largest possible mismatch count.
	localparam logic [ERR_W-1:0] ERR_MAX = 5'd24;

	// Configuration register contents.
	typedef struct packed {
		logic [SYNC_W-1:0] sync_pattern;
		logic [ERR_W-1:0]  error_limit;
	} cfg_t;

	// One captured word with the history that stood before it.
	typedef struct packed {
		logic [BYTE_W-1:0] cur;
		logic [HIST_W-1:0] history;
		logic              aligned_en;
		logic              offset_en;
	} window_t;

	// Registered result of both checks.
	typedef struct packed {
		logic               aligned_hit;
		logic [ERR_W-1:0]   aligned_errors;
		logic [FRAME_W-1:0] aligned_frame;
		logic               offset_hit;
		logic [ERR_W-1:0]   offset_errors;
		logic [FRAME_W-1:0] offset_frame;
	} result_t;

	// Popcount as a small adder tree: six nibble counts, three pair sums, one total.
	function automatic logic [ERR_W-1:0] popcount24(input logic [SYNC_W-1:0] v);
		logic [2:0] nib [6];
		logic [3:0] pair [3];
		for (int i = 0; i < 6; i++) begin
			nib[i] = {2'b00, v[4*i]} + {2'b00, v[4*i+1]}
				+ {2'b00, v[4*i+2]} + {2'b00, v[4*i+3]};
		end
		for (int j = 0; j < 3; j++) begin
			pair[j] = {1'b0, nib[2*j]} + {1'b0, nib[2*j+1]};
		end
		return {1'b0, pair[0]} + {1'b0, pair[1]} + {1'b0, pair[2]};
	endfunction

endpackage

### src/swetd_if.sv
// ----------------------------------------------------------------------------
// swetd_if: stream interfaces of the sync word detector
// Byte input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------

// Raw byte channel.
interface swetd_byte_if;
	logic                           valid;
	logic                           ready;
	logic [swetd_pkg::BYTE_W-1:0]   byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink   (input valid, input byte_in, output ready);
endinterface

// Result channel, one word per input byte.
interface swetd_result_if;
	logic                           valid;
	logic                           ready;
	logic                           aligned_hit;
	logic [swetd_pkg::ERR_W-1:0]    aligned_errors;
	logic [swetd_pkg::FRAME_W-1:0]  aligned_frame;
	logic                           offset_hit;
	logic [swetd_pkg::ERR_W-1:0]    offset_errors;
	logic [swetd_pkg::FRAME_W-1:0]  offset_frame;

	modport source (output valid, output aligned_hit, output aligned_errors,
		output aligned_frame, output offset_hit, output offset_errors,
		output offset_frame, input ready);
	modport sink   (input valid, input aligned_hit, input aligned_errors,
		input aligned_frame, input offset_hit, input offset_errors,
		input offset_frame, output ready);
endinterface

// Configuration write channel.
interface swetd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [swetd_pkg::CFG_IDX_W-1:0]  index;
	logic [swetd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### src/sync_word_error_tolerant_detector.sv
// ----------------------------------------------------------------------------
// sync_word_error_tolerant_detector: frame sync correlator with error tolerance
// Checks every byte for a 24-bit sync word at byte and nibble offsets.
// ----------------------------------------------------------------------------
// A byte accepted into the input register moves to the result register once
// that is empty or being read, and one byte can be accepted every cycle while
// the sink takes results: the input register feeds two popcount-compare checks
// whose outputs land in the result register, which holds while the sink stalls.
// The aligned check looks at the three bytes before the current byte, the
// offset check at the four bytes before it shifted by a nibble.
// Hits stay low until three (aligned) or four (offset) bytes were seen;
// error counts and frame numbers are reported from the start. Configuration
// must be written only while the block is idle; the block does not enforce it.
module sync_word_error_tolerant_detector (
	input  logic          clk,
	input  logic          arst_n,
	swetd_byte_if.sink    byte_ch,
	swetd_result_if.source result_ch,
	swetd_cfg_if.sink     cfg_ch
);

	swetd_pkg::cfg_t      regs;
	swetd_pkg::window_t   win_s1;
	swetd_pkg::result_t   res_d;
	swetd_pkg::result_t   res_s2;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 advance;

	swetd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.regs   (regs)
	);

	swetd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_ch  (byte_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.win_s1   (win_s1)
	);

	swetd_check u_aligned (
		.window  (win_s1.history[23:0]),
		.pattern (regs.sync_pattern),
		.limit   (regs.error_limit),
		.enable  (win_s1.aligned_en),
		.errors  (res_d.aligned_errors),
		.hit     (res_d.aligned_hit)
	);

	swetd_check u_offset (
		.window  (win_s1.history[27:4]),
		.pattern (regs.sync_pattern),
		.limit   (regs.error_limit),
		.enable  (win_s1.offset_en),
		.errors  (res_d.offset_errors),
		.hit     (res_d.offset_hit)
	);

	// Frame numbers: current bits 6:0, or previous bits 2:0 with current bits 7:4.
	assign res_d.aligned_frame = win_s1.cur[swetd_pkg::FRAME_W-1:0];
	assign res_d.offset_frame  = {win_s1.history[2:0], win_s1.cur[7:4]};

	// The result register takes a word when it is empty or being read.
	assign advance = valid_s1 && (!valid_s2 || result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	// Output drive.
	assign result_ch.valid          = valid_s2;
	assign result_ch.aligned_hit    = res_s2.aligned_hit;
	assign result_ch.aligned_errors = res_s2.aligned_errors;
	assign result_ch.aligned_frame  = res_s2.aligned_frame;
	assign result_ch.offset_hit     = res_s2.offset_hit;
	assign result_ch.offset_errors  = res_s2.offset_errors;
	assign result_ch.offset_frame   = res_s2.offset_frame;

	// A result word only appears after the input stage held one.
	a_result_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result valid rose without an input stage word");

	// A reported hit never exceeds the error limit.
	a_hit_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.aligned_hit || res_s2.offset_hit) |->
		((!res_s2.aligned_hit || res_s2.aligned_errors <= regs.error_limit) &&
		(!res_s2.offset_hit || res_s2.offset_errors <= regs.error_limit)))
		else $error("hit reported above the error limit");

	// Mismatch counts stay within the window width.
	a_errors_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.aligned_errors <= swetd_pkg::ERR_MAX &&
		res_s2.offset_errors <= swetd_pkg::ERR_MAX))
		else $error("mismatch count out of range");

endmodule

### src/swetd_cfg_regs.sv
// ----------------------------------------------------------------------------
// swetd_cfg_regs: configuration registers
// Holds the sync pattern and the error limit; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module swetd_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	swetd_cfg_if.sink         cfg,
	output swetd_pkg::cfg_t   regs
);

	swetd_pkg::cfg_t regs_q;

	// Writes are always taken.
	assign cfg.ready = 1'b1;

	// Register file update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.sync_pattern <= swetd_pkg::SYNC_RESET;
			regs_q.error_limit  <= swetd_pkg::LIMIT_RESET;
		end else if (cfg.valid) begin
			if (cfg.index == swetd_pkg::REG_SYNC_PATTERN) begin
				regs_q.sync_pattern <= cfg.data[swetd_pkg::SYNC_W-1:0];
			end else if (cfg.index == swetd_pkg::REG_ERROR_LIMIT) begin
				regs_q.error_limit <= cfg.data[swetd_pkg::ERR_W-1:0];
			end
		end
	end

	assign regs = regs_q;

endmodule

### src/swetd_front.sv
// ----------------------------------------------------------------------------
// swetd_front: byte history and input register
// Captures each accepted byte together with the history before it.
// ----------------------------------------------------------------------------
module swetd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	swetd_byte_if.sink           byte_ch,
	input  logic                 advance,
	output logic                 valid_s1,
	output swetd_pkg::window_t   win_s1
);

	logic [swetd_pkg::HIST_W-1:0] history_q;
	logic [swetd_pkg::FILL_W-1:0] fill_q;
	logic                         valid_q;
	logic                         accept;

	// A new word enters when the stage is empty or moves on this cycle.
	assign byte_ch.ready = !valid_q || advance;
	assign accept        = byte_ch.valid && byte_ch.ready;

	// History shift and saturating fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			history_q <= '0;
			fill_q    <= '0;
		end else if (accept) begin
			history_q <= {history_q[swetd_pkg::HIST_W-swetd_pkg::BYTE_W-1:0],
				byte_ch.byte_in};
			if (fill_q < swetd_pkg::FILL_FULL) begin
				fill_q <= fill_q + 3'd1;
			end
		end
	end

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (advance) begin
			valid_q <= 1'b0;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			win_s1.cur        <= byte_ch.byte_in;
			win_s1.history    <= history_q;
			win_s1.aligned_en <= fill_q >= swetd_pkg::FILL_ALIGNED;
			win_s1.offset_en  <= fill_q >= swetd_pkg::FILL_FULL;
		end
	end

	assign valid_s1 = valid_q;

endmodule

### src/swetd_check.sv
// ----------------------------------------------------------------------------
// swetd_check: one correlation check
// Counts mismatched bits of a 24-bit window and compares with the limit.
// ----------------------------------------------------------------------------
module swetd_check (
	input  logic [swetd_pkg::SYNC_W-1:0] window,
	input  logic [swetd_pkg::SYNC_W-1:0] pattern,
	input  logic [swetd_pkg::ERR_W-1:0]  limit,
	input  logic                         enable,
	output logic [swetd_pkg::ERR_W-1:0]  errors,
	output logic                         hit
);

	// Mismatch count and threshold.
	always_comb begin
		errors = swetd_pkg::popcount24(window ^ pattern);
		hit    = enable && (errors <= limit);
	end

endmodule

### sim/tb_sync_word_error_tolerant_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_word_error_tolerant_detector: self-checking bench of the sync detector
// Streams bytes through the detector and predicts every result word. The
// stimulus is mostly sync words with a chosen number of flipped bits, at byte
// and nibble offsets, mixed with noise, under several register settings and
// with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_sync_word_error_tolerant_detector;

	localparam int unsigned CLK_HALF     = 5;
	localparam int unsigned RESET_CYCLES = 12;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned LONG_HOLD    = 300;
	localparam int unsigned LIMIT_CYCLES = 400000;
	localparam int unsigned MAX_REPORTS  = 10;

	// Local shorthands for the field widths.
	typedef logic [swetd_pkg::BYTE_W-1:0]     byte_t;
	typedef logic [swetd_pkg::ERR_W-1:0]      err_t;
	typedef logic [swetd_pkg::SYNC_W-1:0]     sync_t;
	typedef logic [swetd_pkg::CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [swetd_pkg::CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [4:0]                       bit_idx_t;

	// Indexes that map to no register; writes to them must be dropped.
	localparam cfg_idx_t REG_UNUSED_LO = 4'd2;
	localparam cfg_idx_t REG_UNUSED_HI = 4'd15;

	logic clk;
	logic arst_n;

	swetd_byte_if   byte_ch ();
	swetd_result_if result_ch ();
	swetd_cfg_if    cfg_ch ();

	sync_word_error_tolerant_detector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	// Bytes waiting to be offered and result words still owed by the detector.
	byte_t                bytes_to_send [$];
	swetd_pkg::result_t   sync_reports_due [$];

	// Shadow of the detector: registers, recent bytes and fill level.
	swetd_pkg::cfg_t                 cur_cfg;
	logic [swetd_pkg::HIST_W-1:0]    seen_bytes;
	logic [swetd_pkg::FILL_W-1:0]    bytes_held;

	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          hold_arm;
	logic        long_hold;

	// Expected result word for one byte, from the history before it.
	function automatic swetd_pkg::result_t correlate_byte(input byte_t cur);
		swetd_pkg::result_t r;
		sync_t              win_a;
		sync_t              win_o;
		win_a            = seen_bytes[23:0];
		win_o            = seen_bytes[27:4];
		r.aligned_errors = err_t'($countones(win_a ^ cur_cfg.sync_pattern));
		r.offset_errors  = err_t'($countones(win_o ^ cur_cfg.sync_pattern));
		r.aligned_hit    = (bytes_held >= swetd_pkg::FILL_ALIGNED)
			&& (r.aligned_errors <= cur_cfg.error_limit);
		r.offset_hit     = (bytes_held >= swetd_pkg::FILL_FULL)
			&& (r.offset_errors <= cur_cfg.error_limit);
		r.aligned_frame  = cur[6:0];
		r.offset_frame   = {seen_bytes[2:0], cur[7:4]};
		return r;
	endfunction

	// A mask with exactly k bits set, k at most 24.
	function automatic sync_t flip_bits(input int k);
		sync_t m;
		m = '0;
		while ($countones(m) < k) begin
			m[bit_idx_t'($urandom_range(swetd_pkg::SYNC_W - 1, 0))] = 1'b1;
		end
		return m;
	endfunction

	// Queue about n bytes: sync words with random errors at either offset,
	// each followed by a frame byte, with runs of noise in between.
	task automatic queue_stream(input int n);
		int    count;
		int    kind;
		int    k;
		int    runs;
		sync_t w;
		count = 0;
		while (count < n) begin
			kind = $urandom_range(99);
			k    = $urandom_range(cur_cfg.error_limit + 2, 0);
			if (k > 24) begin
				k = 24;
			end
			w = cur_cfg.sync_pattern ^ flip_bits(k);
			if (kind < 35) begin
				bytes_to_send.push_back(w[23:16]);
				bytes_to_send.push_back(w[15:8]);
				bytes_to_send.push_back(w[7:0]);
				bytes_to_send.push_back(byte_t'($urandom));
				count += 4;
			end else if (kind < 65) begin
				bytes_to_send.push_back({4'($urandom), w[23:20]});
				bytes_to_send.push_back(w[19:12]);
				bytes_to_send.push_back(w[11:4]);
				bytes_to_send.push_back({w[3:0], 4'($urandom)});
				bytes_to_send.push_back(byte_t'($urandom));
				count += 5;
			end else begin
				runs = $urandom_range(6, 1);
				repeat (runs) bytes_to_send.push_back(byte_t'($urandom));
				count += runs;
			end
		end
	endtask

	// Block until every queued byte went in and every result word came out.
	task automatic wait_drained();
		do @(posedge clk);
		while (bytes_to_send.size() != 0 || byte_ch.valid
			|| sync_reports_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write over the configuration channel.
	task automatic write_register(input cfg_idx_t idx, input cfg_data_t val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == swetd_pkg::REG_SYNC_PATTERN) begin
			cur_cfg.sync_pattern = val[swetd_pkg::SYNC_W-1:0];
		end else if (idx == swetd_pkg::REG_ERROR_LIMIT) begin
			cur_cfg.error_limit = val[swetd_pkg::ERR_W-1:0];
		end
	endtask

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Byte driver: predicts each accepted word and offers the next byte.
	always @(posedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready) begin
				sync_reports_due.push_back(correlate_byte(byte_ch.byte_in));
				seen_bytes = {seen_bytes[23:0], byte_ch.byte_in};
				if (bytes_held < swetd_pkg::FILL_FULL) begin
					bytes_held = bytes_held + 1'b1;
				end
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (bytes_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
					byte_ch.valid   <= 1'b1;
					byte_ch.byte_in <= bytes_to_send.pop_front();
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each accepted word against the oldest prediction.
	always @(posedge clk) begin
		swetd_pkg::result_t seen;
		swetd_pkg::result_t due;
		if (arst_n) begin
			if (result_ch.valid && result_ch.ready) begin
				seen = {result_ch.aligned_hit, result_ch.aligned_errors,
					result_ch.aligned_frame, result_ch.offset_hit,
					result_ch.offset_errors, result_ch.offset_frame};
				if (sync_reports_due.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("unexpected result word %h at cycle %0d", seen, cycle_count);
					end
				end else begin
					due = sync_reports_due.pop_front();
					if (seen !== due) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS) begin
							$display({"mismatch at cycle %0d: aligned hit/err/frame ",
								"exp %b/%0d/%h got %b/%0d/%h"},
								cycle_count,
								due.aligned_hit, due.aligned_errors, due.aligned_frame,
								seen.aligned_hit, seen.aligned_errors, seen.aligned_frame);
							$display("  offset hit/err/frame exp %b/%0d/%h got %b/%0d/%h",
								due.offset_hit, due.offset_errors, due.offset_frame,
								seen.offset_hit, seen.offset_errors, seen.offset_frame);
						end
					end
				end
			end
			result_ch.ready <= !long_hold && ($urandom_range(99) >= stall_pct);
		end
	end

	// Long receiver hold-off, so the detector fills and stalls its input.
	initial begin
		long_hold = 1'b0;
		wait (hold_arm);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("tb_sync_word_error_tolerant_detector: FAIL");
			$finish;
		end
	end

	// Test sequence: reset, directed bytes, then random phases per setting.
	initial begin
		byte_t directed [$];
		byte_ch.valid    = 1'b0;
		byte_ch.byte_in  = '0;
		result_ch.ready  = 1'b0;
		cfg_ch.valid     = 1'b0;
		cfg_ch.index     = swetd_pkg::REG_SYNC_PATTERN;
		cfg_ch.data      = '0;
		arst_n           = 1'b0;
		hold_arm         = 1'b0;
		idle_pct         = 0;
		stall_pct        = 0;
		mismatch_count   = 0;
		cycle_count      = 0;
		cur_cfg.sync_pattern = swetd_pkg::SYNC_RESET;
		cur_cfg.error_limit  = swetd_pkg::LIMIT_RESET;
		seen_bytes       = '0;
		bytes_held       = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings. A sync word right at start-up, then extremes, a
		// nibble-offset sync, and windows with one, two and three bad bits.
		directed = '{8'hF9, 8'hA8, 8'hED, 8'h12, 8'h00, 8'hFF, 8'h0F, 8'h9A,
			8'h8E, 8'hD5, 8'h3C, 8'hF9, 8'hA8, 8'hEC, 8'h80, 8'hF8, 8'hA8,
			8'hEC, 8'h7F, 8'hF8, 8'hA9, 8'hEC, 8'hFF, 8'h00};
		foreach (directed[i]) bytes_to_send.push_back(directed[i]);
		wait_drained();

		// Writes to unused indexes are dropped; a zero limit with junk in the
		// upper data bits; no idling.
		write_register(REG_UNUSED_LO, cfg_data_t'($urandom));
		write_register(REG_UNUSED_HI, cfg_data_t'($urandom));
		write_register(swetd_pkg::REG_ERROR_LIMIT, {19'($urandom), 5'd0});
		write_register(swetd_pkg::REG_SYNC_PATTERN, cfg_data_t'($urandom));
		queue_stream(350);
		wait_drained();

		// Largest meaningful limit, all-zero pattern, sender idling.
		write_register(swetd_pkg::REG_ERROR_LIMIT, cfg_data_t'(swetd_pkg::ERR_MAX));
		write_register(swetd_pkg::REG_SYNC_PATTERN, '0);
		idle_pct = 67;
		queue_stream(300);
		wait_drained();

		// Limit above the window width, all-ones pattern, receiver stalling
		// plus one long hold-off while the sender keeps offering.
		write_register(swetd_pkg::REG_ERROR_LIMIT, '1);
		write_register(swetd_pkg::REG_SYNC_PATTERN, '1);
		idle_pct  = 0;
		stall_pct = 67;
		queue_stream(300);
		hold_arm = 1'b1;
		wait_drained();

		// Small limit, both sides idling, and a sender pause half way.
		write_register(swetd_pkg::REG_ERROR_LIMIT, cfg_data_t'(3));
		write_register(swetd_pkg::REG_SYNC_PATTERN, cfg_data_t'($urandom));
		idle_pct  = 37;
		stall_pct = 37;
		queue_stream(150);
		wait_drained();
		queue_stream(150);
		wait_drained();

		// Back to the reset pattern with a random limit, no idling.
		write_register(swetd_pkg::REG_ERROR_LIMIT, cfg_data_t'($urandom_range(24, 0)));
		write_register(swetd_pkg::REG_SYNC_PATTERN, swetd_pkg::SYNC_RESET);
		idle_pct  = 0;
		stall_pct = 0;
		queue_stream(400);
		wait_drained();

		if (mismatch_count == 0 && sync_reports_due.size() == 0) begin
			$display("tb_sync_word_error_tolerant_detector: PASS");
		end else begin
			$display("tb_sync_word_error_tolerant_detector: FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
src/swetd_pkg.sv
src/swetd_if.sv
src/swetd_cfg_regs.sv
src/swetd_front.sv
src/swetd_check.sv
src/sync_word_error_tolerant_detector.sv
sim/tb_sync_word_error_tolerant_detector.sv
